>>> rtl/symbol_name_hash_defines.svh
// Assertion macros shared by the checkers of the symbol name hash block.
// Depends on nothing; included by rtl/snh_checker.sv.
`ifndef SYMBOL_NAME_HASH_DEFINES_SVH
`define SYMBOL_NAME_HASH_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SNH_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SNH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is checked through reset as well.
`define SNH_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/snh_pkg.sv
// Package of the symbol name hash block: field widths, hash constants, prime default.
// Depends on nothing; used by the interfaces, the top level and the checker.
`timescale 1ns / 1ps

package snh_pkg;

  localparam int CHAR_W   = 8;
  localparam int BUCKET_W = 19;
  localparam int HASH_W   = 32;

  localparam int unsigned TABLE_PRIME_DEFAULT = 500009;

  localparam logic [HASH_W-1:0] TOP_NIBBLE = 32'hF000_0000;
  localparam int NIBBLE_FOLD_SHIFT = 24;
  localparam int MIX_SHIFT         = 3;
  localparam int ELF_SHIFT         = 4;

endpackage

>>> rtl/snh_char_if.sv
// Input channel of the symbol name hash block: one name character per word.
// Depends on snh_pkg.
`timescale 1ns / 1ps

interface snh_char_if import snh_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink (input valid, input char_code, input last_char, output ready);
endinterface

>>> rtl/snh_bucket_if.sv
// Output channel of the symbol name hash block: one bucket index per word.
// Depends on snh_pkg.
`timescale 1ns / 1ps

interface snh_bucket_if import snh_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [BUCKET_W-1:0] bucket;

  modport source (output valid, output bucket, input ready);
  modport sink (input valid, input bucket, output ready);
endinterface

>>> rtl/symbol_name_hash.sv
// Top level of the symbol name hash block: running ELF and mix hashes plus
// a pipelined reduction modulo the table prime. Depends on snh_pkg,
// snh_char_if and snh_bucket_if.
//
//   channel     direction  word
//   name_chars  in         char_code[7:0], last_char
//   buckets     out        bucket[18:0]
//
// One character is taken every cycle while name_chars.ready is high.
// The hash registers update in the cycle a word is accepted; a final
// character enters a five-stage reduction pipeline (two multipliers, a
// subtract and one correction), so its bucket word passes stages s1 to s4
// and the output register and leaves when buckets is ready. Reset clears
// the hashes and empties the pipeline. A stall on buckets backs up through
// the pipeline and drops name_chars.ready only once every stage is full.
`timescale 1ns / 1ps

module symbol_name_hash import snh_pkg::*; #(
  parameter int unsigned TABLE_PRIME = TABLE_PRIME_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  snh_char_if.sink      name_chars,
  snh_bucket_if.source  buckets
);

  // Barrett-style reciprocal: floor(2^32 / P) keeps the quotient estimate
  // at most one short, so a single conditional subtract finishes the job.
  localparam logic [HASH_W-1:0] RECIP  = HASH_W'((64'd1 << HASH_W) / 64'(TABLE_PRIME));
  localparam logic [HASH_W-1:0] PRIME  = HASH_W'(TABLE_PRIME);

  logic [HASH_W-1:0] shift_hash;
  logic [HASH_W-1:0] mix_hash;
  logic [HASH_W-1:0] char_position;

  logic [HASH_W-1:0] ch;
  logic [HASH_W-1:0] elf_sum;
  logic [HASH_W-1:0] elf_top;
  logic [HASH_W-1:0] shift_hash_next;
  logic [HASH_W-1:0] mix_hash_next;
  logic              accept;

  // Reduction pipeline.
  logic                  s1_valid, s2_valid, s3_valid, s4_valid, out_valid;
  logic                  s1_en, s2_en, s3_en, s4_en, out_en;
  logic [HASH_W-1:0]     s1_x, s2_x, s3_x;
  logic [2*HASH_W-1:0]   s2_prod;
  logic [HASH_W-1:0]     s3_qp;
  logic [HASH_W-1:0]     s4_r;
  logic [HASH_W-1:0]     r_fixed;
  logic [BUCKET_W-1:0]   bucket;

  assign ch      = {{(HASH_W-CHAR_W){name_chars.char_code[CHAR_W-1]}}, name_chars.char_code};
  assign elf_sum = (shift_hash << ELF_SHIFT) + ch;
  assign elf_top = elf_sum & TOP_NIBBLE;
  // Folding the top nibble down and XORing it off clears it in one step.
  assign shift_hash_next = elf_sum ^ (elf_top >> NIBBLE_FOLD_SHIFT) ^ elf_top;
  assign mix_hash_next   = (mix_hash << MIX_SHIFT) - (ch + char_position);

  assign out_en = !out_valid || buckets.ready;
  assign s4_en  = !s4_valid || out_en;
  assign s3_en  = !s3_valid || s4_en;
  assign s2_en  = !s2_valid || s3_en;
  assign s1_en  = !s1_valid || s2_en;

  assign name_chars.ready = s1_en;
  assign accept           = name_chars.valid && s1_en;

  assign r_fixed = (s4_r >= PRIME) ? s4_r - PRIME : s4_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_hash    <= '0;
      mix_hash      <= '0;
      char_position <= '0;
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      s3_valid      <= 1'b0;
      s4_valid      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        if (name_chars.last_char) begin
          shift_hash    <= '0;
          mix_hash      <= '0;
          char_position <= '0;
        end else begin
          shift_hash    <= shift_hash_next;
          mix_hash      <= mix_hash_next;
          char_position <= char_position + HASH_W'(1);
        end
      end
      if (s1_en)  s1_valid  <= accept && name_chars.last_char;
      if (s2_en)  s2_valid  <= s1_valid;
      if (s3_en)  s3_valid  <= s2_valid;
      if (s4_en)  s4_valid  <= s3_valid;
      if (out_en) out_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) s1_x <= shift_hash_next ^ mix_hash_next;
    if (s2_en) begin
      s2_x    <= s1_x;
      s2_prod <= s1_x * RECIP;
    end
    if (s3_en) begin
      s3_x  <= s2_x;
      // The estimate times the prime never exceeds x, so 32 bits hold it.
      s3_qp <= HASH_W'(s2_prod[2*HASH_W-1:HASH_W] * PRIME);
    end
    if (s4_en)  s4_r   <= s3_x - s3_qp;
    if (out_en) bucket <= r_fixed[BUCKET_W-1:0];
  end

  assign buckets.valid  = out_valid;
  assign buckets.bucket = bucket;

endmodule

>>> rtl/snh_checker.sv
// Port-level checker for symbol_name_hash, bound to every instance of it.
// Depends on snh_pkg and symbol_name_hash_defines.svh.
`timescale 1ns / 1ps
`include "symbol_name_hash_defines.svh"

module snh_checker import snh_pkg::*; #(
  parameter int unsigned TABLE_PRIME = TABLE_PRIME_DEFAULT
) (
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [BUCKET_W-1:0] bucket
);

  localparam logic [HASH_W-1:0] PRIME      = HASH_W'(TABLE_PRIME);
  localparam logic [HASH_W-1:0] BUCKET_CAP = HASH_W'(64'd1 << BUCKET_W);

  logic [HASH_W-1:0] bucket_wide;
  assign bucket_wide = HASH_W'(bucket);

  `SNH_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(bucket), "bucket word changed while stalled")
  `SNH_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid, "bucket word valid right after reset")
  `SNH_ASSERT_NOW(a_bucket_range, clk, rst, out_valid, PRIME > BUCKET_CAP || bucket_wide < PRIME, "bucket not below the table prime")
  `SNH_ASSERT_NOW(a_ready_when_drained, clk, rst, !out_valid, in_ready, "input stalled while the output is empty")

endmodule

bind symbol_name_hash snh_checker #(.TABLE_PRIME(TABLE_PRIME)) u_snh_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (name_chars.ready),
  .out_valid (buckets.valid),
  .out_ready (buckets.ready),
  .bucket    (buckets.bucket)
);
